// File: hw/rtl/trpa_pkg.sv
// ----------------------------------------------------------------------------
// trpa_pkg
// Shared constants, codes, types and tile helpers for the tile row pool
// allocator.
// ----------------------------------------------------------------------------
package trpa_pkg;

    localparam int BLOCK_COUNT_DEFAULT = 5;
    localparam int BLOCK_COUNT_MAX     = 16;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 8;
    localparam int TILE_W   = 8;
    localparam int ACTION_W = 2;
    localparam int ROWIDX_W = 4;
    localparam int CFG_W    = 8;
    localparam int USE_W    = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_CLAIM_BLOCK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT_BLOCK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLAIM_STRIP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FRAME_END    = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_NONE       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAVE_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESTORE    = 2'd3;

    localparam logic [USE_W-1:0] USE_FREE  = 2'd0;
    localparam logic [USE_W-1:0] USE_BLOCK = 2'd1;
    localparam logic [USE_W-1:0] USE_STRIP = 2'd2;

    localparam logic CFG_SHARED_TILE = 1'b0;
    localparam logic CFG_ROW_STRIDE  = 1'b1;

    localparam logic [TILE_W-1:0] SHARED_TILE_RESET = 8'd36;
    localparam logic [TILE_W-1:0] ROW_STRIDE_RESET  = 8'd16;

    localparam int BASE_COUNT = 5;
    localparam logic [TILE_W-1:0] BLOCK_BASE [BASE_COUNT] =
        '{8'h26, 8'h28, 8'h2a, 8'h2c, 8'h2e};

    typedef struct packed {
        logic latch;
        logic exec;
        logic frame_step;
    } trpa_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             out_free;
        logic             last_row;
    } trpa_stat_t;

    function automatic logic [TILE_W-1:0] block_tile(input logic [7:0] b);
        logic [8:0] t;
        begin
            t = 9'h026 + {b, 1'b0};
            if (b < 8'(BASE_COUNT)) begin
                block_tile = BLOCK_BASE[b[2:0]];
            end else begin
                block_tile = t[7:0];
            end
        end
    endfunction

    function automatic logic [TILE_W-1:0] row_tile(input logic [7:0] r,
                                                   input logic [7:0] stride);
        logic [7:0] base;
        begin
            base = block_tile({1'b0, r[7:1]});
            row_tile = r[0] ? base + stride : base;
        end
    endfunction

endpackage

// File: hw/rtl/tile_row_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// tile_row_pool_allocator_top
// Per-frame pool of tile rows in two-row blocks: block and strip claims,
// commits and the frame-end row action walk.
//
//   Channel  Direction  Payload
//   s_       in         tdata: command[1:0], key[9:2]
//   m_       out        tdata: tile_num[7:0], row_action[9:8], row_index[13:10];
//                       tlast: last
//   cfg_     in         cfg_addr selects shared_tile (0) or row_stride (1)
//
// A claim or commit is accepted, then executed; a claim writes its result
// into the result register once that has room. A frame end steps every row
// (2*BLOCK_COUNT), the row sequencer emitting one row per cycle while m_tready allows.
// A stalled m_tready holds the sequencer; a new transaction is taken only
// once the previous command has finished executing.
// Reset is synchronous and frees every row and restores the configuration register defaults.
// ----------------------------------------------------------------------------
module tile_row_pool_allocator_top #(
    parameter int BLOCK_COUNT = trpa_pkg::BLOCK_COUNT_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [trpa_pkg::S_DATA_W-1:0] s_tdata,   // command, key
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [trpa_pkg::M_DATA_W-1:0] m_tdata,   // tile_num, row_action, row_index
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [trpa_pkg::CFG_W-1:0]    cfg_wdata
);
    import trpa_pkg::*;

    trpa_cmd_t  cmd;
    trpa_stat_t stat;

    trpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    trpa_dp #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: hw/rtl/trpa_ctrl.sv
// ----------------------------------------------------------------------------
// trpa_ctrl
// Sequencer: accepts one transaction, runs its command, steps the frame-end
// row walk while the result register has room.
// ----------------------------------------------------------------------------
module trpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  trpa_pkg::trpa_stat_t stat,
    output trpa_pkg::trpa_cmd_t  cmd
);
    import trpa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FRAME = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.command == CMD_FRAME_END) begin
                    state_next = ST_FRAME;
                end else if (stat.out_free || stat.command == CMD_COMMIT_BLOCK) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FRAME: begin
                if (stat.out_free) begin
                    cmd.frame_step = 1'b1;
                    if (stat.last_row) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/trpa_dp.sv
// ----------------------------------------------------------------------------
// trpa_dp
// Datapath: row pool state, parallel row searches, configuration registers
// and the result register.
// ----------------------------------------------------------------------------
module trpa_dp #(
    parameter int BLOCK_COUNT = trpa_pkg::BLOCK_COUNT_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [trpa_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [trpa_pkg::CFG_W-1:0]    cfg_wdata,
    input  trpa_pkg::trpa_cmd_t           cmd,
    output trpa_pkg::trpa_stat_t          stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [trpa_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import trpa_pkg::*;

    localparam int ROW_COUNT = 2 * BLOCK_COUNT;
    localparam int RW = $clog2(ROW_COUNT);
    localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    logic [USE_W-1:0] row_use_reg     [ROW_COUNT];
    logic [USE_W-1:0] row_use_next    [ROW_COUNT];
    logic [KEY_W-1:0] row_owner_reg   [ROW_COUNT];
    logic [KEY_W-1:0] row_owner_next  [ROW_COUNT];
    logic [ROW_COUNT-1:0] row_pending_reg, row_pending_next;
    logic [ROW_COUNT-1:0] row_holding_reg, row_holding_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [RW-1:0]     cnt_reg, cnt_next;
    logic [TILE_W-1:0] shared_tile_reg, row_stride_reg;

    logic                out_valid_reg, out_valid_next;
    logic [TILE_W-1:0]   out_tile_reg, out_tile_next;
    logic [ACTION_W-1:0] out_action_reg, out_action_next;
    logic [ROWIDX_W-1:0] out_index_reg, out_index_next;
    logic                out_last_reg, out_last_next;
    logic                out_load;

    logic          hit_found, free_found, sh_found, sf_found;
    logic [BW-1:0] hit_blk, free_blk;
    logic [RW-1:0] sh_row, sf_row, top_row, bot_row;

    assign out_load      = cmd.frame_step || (cmd.exec && cmd_reg != CMD_COMMIT_BLOCK);
    assign stat.command  = cmd_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.last_row = (cnt_reg == RW'(ROW_COUNT - 1));

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_index_reg, out_action_reg, out_tile_reg});

    always_comb begin
        hit_found  = 1'b0;
        hit_blk    = '0;
        free_found = 1'b0;
        free_blk   = '0;
        sh_found   = 1'b0;
        sh_row     = '0;
        sf_found   = 1'b0;
        sf_row     = '0;
        for (int b = 0; b < BLOCK_COUNT; b++) begin
            if (!hit_found && row_use_reg[2*b] == USE_BLOCK
                && row_owner_reg[2*b] == key_reg) begin
                hit_found = 1'b1;
                hit_blk   = BW'(b);
            end
            if (!free_found && row_use_reg[2*b] == USE_FREE
                && row_use_reg[2*b+1] == USE_FREE) begin
                free_found = 1'b1;
                free_blk   = BW'(b);
            end
        end
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (!sh_found && row_use_reg[r] == USE_STRIP && row_owner_reg[r] == key_reg) begin
                sh_found = 1'b1;
                sh_row   = RW'(r);
            end
            if (row_use_reg[r] == USE_FREE) begin
                sf_found = 1'b1;
                sf_row   = RW'(r);
            end
        end
    end

    always_comb begin
        row_use_next     = row_use_reg;
        row_owner_next   = row_owner_reg;
        row_pending_next = row_pending_reg;
        row_holding_next = row_holding_reg;
        cnt_next         = cnt_reg;
        out_tile_next    = out_tile_reg;
        out_action_next  = out_action_reg;
        out_index_next   = out_index_reg;
        out_last_next    = out_last_reg;
        top_row          = '0;
        bot_row          = '0;

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        if (cmd.latch) begin
            cnt_next = '0;
        end

        if (cmd.exec) begin
            if (out_load) begin
                out_action_next = ACT_NONE;
                out_last_next   = 1'b1;
            end
            case (cmd_reg)
                CMD_CLAIM_BLOCK: begin
                    if (hit_found) begin
                        out_tile_next  = block_tile(8'(hit_blk));
                        out_index_next = ROWIDX_W'({hit_blk, 1'b0});
                    end else if (free_found) begin
                        top_row = RW'({free_blk, 1'b0});
                        bot_row = top_row | RW'(1);
                        row_use_next[top_row]   = USE_BLOCK;
                        row_use_next[bot_row]   = USE_BLOCK;
                        row_owner_next[top_row] = key_reg;
                        row_owner_next[bot_row] = key_reg;
                        out_tile_next  = block_tile(8'(free_blk));
                        out_index_next = ROWIDX_W'({free_blk, 1'b0});
                    end else begin
                        out_tile_next  = shared_tile_reg;
                        out_index_next = '0;
                    end
                end
                CMD_COMMIT_BLOCK: begin
                    if (hit_found) begin
                        top_row = RW'({hit_blk, 1'b0});
                        bot_row = top_row | RW'(1);
                        row_pending_next[top_row] = 1'b1;
                        row_pending_next[bot_row] = 1'b1;
                    end
                end
                CMD_CLAIM_STRIP: begin
                    if (sh_found) begin
                        out_tile_next  = row_tile(8'(sh_row), row_stride_reg);
                        out_index_next = ROWIDX_W'(sh_row);
                    end else if (sf_found) begin
                        row_use_next[sf_row]     = USE_STRIP;
                        row_owner_next[sf_row]   = key_reg;
                        row_pending_next[sf_row] = 1'b1;
                        out_tile_next  = row_tile(8'(sf_row), row_stride_reg);
                        out_index_next = ROWIDX_W'(sf_row);
                    end else begin
                        out_tile_next  = '0;
                        out_index_next = '0;
                    end
                end
                default: begin
                    out_tile_next = out_tile_reg;
                end
            endcase
        end

        if (cmd.frame_step) begin
            if (row_pending_reg[cnt_reg]) begin
                out_action_next = row_holding_reg[cnt_reg] ? ACT_WRITE : ACT_SAVE_WRITE;
                row_holding_next[cnt_reg] = 1'b1;
            end else if (row_holding_reg[cnt_reg]) begin
                out_action_next = ACT_RESTORE;
                row_holding_next[cnt_reg] = 1'b0;
            end else begin
                out_action_next = ACT_NONE;
            end
            row_pending_next[cnt_reg] = 1'b0;
            row_use_next[cnt_reg]     = USE_FREE;
            out_tile_next  = row_tile(8'(cnt_reg), row_stride_reg);
            out_index_next = ROWIDX_W'(cnt_reg);
            out_last_next  = stat.last_row;
            cnt_next       = stat.last_row ? '0 : cnt_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                row_use_reg[r]   <= USE_FREE;
                row_owner_reg[r] <= '0;
            end
            row_pending_reg <= '0;
            row_holding_reg <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            shared_tile_reg <= SHARED_TILE_RESET;
            row_stride_reg  <= ROW_STRIDE_RESET;
        end else begin
            row_use_reg     <= row_use_next;
            row_owner_reg   <= row_owner_next;
            row_pending_reg <= row_pending_next;
            row_holding_reg <= row_holding_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we && cfg_addr == CFG_SHARED_TILE) begin
                shared_tile_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == CFG_ROW_STRIDE) begin
                row_stride_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cmd_reg <= s_tdata[CMD_W-1:0];
            key_reg <= s_tdata[CMD_W +: KEY_W];
        end
        out_tile_reg   <= out_tile_next;
        out_action_reg <= out_action_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// File: hw/rtl/trpa_checker.sv
// ----------------------------------------------------------------------------
// trpa_checker
// Port-level checks for the tile row pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module trpa_checker #(
    parameter int BLOCK_COUNT = trpa_pkg::BLOCK_COUNT_DEFAULT
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [trpa_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import trpa_pkg::*;

    localparam int ROW_COUNT = 2 * BLOCK_COUNT;

    logic [ROWIDX_W-1:0] idx;
    assign idx = m_tdata[TILE_W + ACTION_W +: ROWIDX_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("transaction accepted while previous one executes");

    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during frame-end walk");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ROW_COUNT > 16) || (32'(idx) < ROW_COUNT))
        else $error("row index out of range");

    a_action_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tdata[TILE_W +: ACTION_W] != ACT_NONE
        |-> idx == ROWIDX_W'(ROW_COUNT - 1))
        else $error("row action on a claim result");

endmodule

bind tile_row_pool_allocator_top trpa_checker #(
    .BLOCK_COUNT (BLOCK_COUNT)
) u_trpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
